@@ hw/rtl/mesh_face_match_engine_macros.svh @@
// Assertion macros for the face match engine.
`ifndef MESH_FACE_MATCH_ENGINE_MACROS_SVH
`define MESH_FACE_MATCH_ENGINE_MACROS_SVH
`ifndef SYNTHESIS
`define MFM_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define MFM_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define MFM_ASSERT_IMP(label, clk, rst, ante, cons)
`define MFM_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

@@ hw/rtl/mfm_pkg.sv @@
`default_nettype none
package mfm_pkg;
   localparam int MAX_FACES = 4096;
   localparam int NV        = 4;
   localparam int VERT_W    = 32;
   localparam int SLOT_W    = 12;
   localparam int CNT_W     = 13;
   localparam int W_W       = 14;
   localparam int SUM_W     = 15;
   localparam int K_W       = 3;
   localparam int ELT_W     = 32;
   localparam int FACE_W    = 3;
   localparam int KEY_W     = NV * VERT_W;

   // req_func codes
   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_READ = 1'b1;

   typedef logic [KEY_W-1:0] key_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_INIT, ST_M_CHK, ST_M_ORD, ST_M_VTX, ST_M_CMP,
      ST_S_CHK, ST_S_ORD, ST_S_VTX, ST_S_CMP, ST_S_WRB
   } state_type;

   typedef struct packed {
      logic load;
      logic read;
      logic sort_start;
      logic init_step;
      logic first_run;
      logic next_run;
      logic pass_end;
      logic flip;
      logic m_ord;
      logic m_vtx;
      logic m_cmp;
      logic scan_start;
      logic s_ord;
      logic s_vtx;
      logic s_cmp;
      logic s_wrb;
   } dp_cmd_type;

   typedef struct packed {
      logic init_left;
      logic n_gt1;
      logic run_left;
      logic more_runs;
      logic more_passes;
      logic scan_left;
      logic pair_eq;
   } dp_status_type;

   function automatic logic [K_W-1:0] clamp_k(input logic [K_W-1:0] v);
      logic [K_W-1:0] r;
      r = v;
      if (v < K_W'(2)) r = K_W'(2);
      if (v > K_W'(NV)) r = K_W'(NV);
      return r;
   endfunction

   // sort the first k lanes ascending, rest untouched
   function automatic key_type sort_key(input key_type v, input logic [K_W-1:0] k);
      logic [VERT_W-1:0] x [NV];
      logic [VERT_W-1:0] t;
      key_type r;
      for (int i = 0; i < NV; i++) x[i] = v[i*VERT_W +: VERT_W];
      if (k == K_W'(4)) begin
         if (x[0] > x[1]) begin t = x[0]; x[0] = x[1]; x[1] = t; end
         if (x[2] > x[3]) begin t = x[2]; x[2] = x[3]; x[3] = t; end
         if (x[0] > x[2]) begin t = x[0]; x[0] = x[2]; x[2] = t; end
         if (x[1] > x[3]) begin t = x[1]; x[1] = x[3]; x[3] = t; end
         if (x[1] > x[2]) begin t = x[1]; x[1] = x[2]; x[2] = t; end
      end else if (k == K_W'(3)) begin
         if (x[0] > x[1]) begin t = x[0]; x[0] = x[1]; x[1] = t; end
         if (x[1] > x[2]) begin t = x[1]; x[1] = x[2]; x[2] = t; end
         if (x[0] > x[1]) begin t = x[0]; x[0] = x[1]; x[1] = t; end
      end else begin
         if (x[0] > x[1]) begin t = x[0]; x[0] = x[1]; x[1] = t; end
      end
      for (int i = 0; i < NV; i++) r[i*VERT_W +: VERT_W] = x[i];
      return r;
   endfunction

   function automatic logic tuple_after(input key_type a, input key_type b,
                                        input logic [K_W-1:0] k);
      logic gt;
      logic done;
      gt = 1'b0;
      done = 1'b0;
      for (int j = 0; j < NV; j++) begin
         if (j < int'(k) && !done && a[j*VERT_W +: VERT_W] != b[j*VERT_W +: VERT_W]) begin
            gt = a[j*VERT_W +: VERT_W] > b[j*VERT_W +: VERT_W];
            done = 1'b1;
         end
      end
      return gt;
   endfunction

   function automatic logic tuple_eq(input key_type a, input key_type b,
                                     input logic [K_W-1:0] k);
      logic eq;
      eq = 1'b1;
      for (int j = 0; j < NV; j++) begin
         if (j < int'(k) && a[j*VERT_W +: VERT_W] != b[j*VERT_W +: VERT_W]) eq = 1'b0;
      end
      return eq;
   endfunction
endpackage
`default_nettype wire

@@ hw/rtl/mfm_ctrl.sv @@
`default_nettype none
module mfm_ctrl
   import mfm_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic          req_func,
   input  wire logic          req_last_face,
   input  wire dp_status_type status,
   output logic               busy,
   output dp_cmd_type         cmd
);
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start && req_func == FUNC_LOAD && req_last_face) state_in = ST_INIT;
         end
         ST_INIT: begin
            if (!status.init_left) state_in = status.n_gt1 ? ST_M_CHK : ST_S_CHK;
         end
         ST_M_CHK: begin
            if (status.run_left) state_in = ST_M_ORD;
            else if (!status.more_runs && !status.more_passes) state_in = ST_S_CHK;
         end
         ST_M_ORD: state_in = ST_M_VTX;
         ST_M_VTX: state_in = ST_M_CMP;
         ST_M_CMP: state_in = ST_M_CHK;
         ST_S_CHK: state_in = status.scan_left ? ST_S_ORD : ST_IDLE;
         ST_S_ORD: state_in = ST_S_VTX;
         ST_S_VTX: state_in = ST_S_CMP;
         ST_S_CMP: state_in = status.pair_eq ? ST_S_WRB : ST_S_CHK;
         ST_S_WRB: state_in = ST_S_CHK;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = (state_ff != ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            cmd.load       = start && req_func == FUNC_LOAD;
            cmd.read       = start && req_func == FUNC_READ;
            cmd.sort_start = start && req_func == FUNC_LOAD && req_last_face;
         end
         ST_INIT: begin
            if (status.init_left) cmd.init_step = 1'b1;
            else if (status.n_gt1) cmd.first_run = 1'b1;
            else cmd.scan_start = 1'b1;
         end
         ST_M_CHK: begin
            if (!status.run_left) begin
               if (status.more_runs) cmd.next_run = 1'b1;
               else if (status.more_passes) begin
                  cmd.pass_end = 1'b1;
                  cmd.flip     = 1'b1;
               end else begin
                  cmd.scan_start = 1'b1;
                  cmd.flip       = 1'b1;
               end
            end
         end
         ST_M_ORD: cmd.m_ord = 1'b1;
         ST_M_VTX: cmd.m_vtx = 1'b1;
         ST_M_CMP: cmd.m_cmp = 1'b1;
         ST_S_CHK: cmd = '0;
         ST_S_ORD: cmd.s_ord = 1'b1;
         ST_S_VTX: cmd.s_vtx = 1'b1;
         ST_S_CMP: cmd.s_cmp = 1'b1;
         ST_S_WRB: cmd.s_wrb = 1'b1;
         default:  cmd = '0;
      endcase
   end
endmodule
`default_nettype wire

@@ hw/rtl/mfm_datapath.sv @@
`default_nettype none
module mfm_datapath
   import mfm_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire dp_cmd_type               cmd,
   output dp_status_type                 status,
   input  wire logic                     csr_write_enable,
   input  wire logic [K_W-1:0]           csr_write_data,
   input  wire logic [VERT_W-1:0]        req_vert_a,
   input  wire logic [VERT_W-1:0]        req_vert_b,
   input  wire logic [VERT_W-1:0]        req_vert_c,
   input  wire logic [VERT_W-1:0]        req_vert_d,
   input  wire logic [ELT_W-1:0]         req_owner_element,
   input  wire logic [FACE_W-1:0]        req_face_number,
   input  wire logic [SLOT_W-1:0]        req_slot_index,
   input  wire logic                     req_last_face,
   output logic                          rsp_valid,
   output logic [ELT_W-1:0]              rsp_slot_element,
   output logic [FACE_W-1:0]             rsp_slot_face,
   output logic signed [ELT_W:0]         rsp_neighbor_element,
   output logic signed [FACE_W:0]        rsp_neighbor_face
);
   localparam int EF_W = ELT_W + FACE_W;

   // storage
   key_type            vtx_mem [MAX_FACES];
   logic [EF_W-1:0]    ef_mem  [MAX_FACES];
   logic [EF_W:0]      mt_mem  [MAX_FACES];
   logic [SLOT_W-1:0]  ord_mem [2*MAX_FACES];

   logic [K_W-1:0]    vpf_ff, vpf_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              closed_ff, closed_in;
   logic              bank_ff, bank_in;
   logic [W_W-1:0]    w_ff, w_in;
   logic [CNT_W-1:0]  i_ff, i_in, p_ff, p_in, q_ff, q_in, o_ff, o_in;
   logic [CNT_W-1:0]  mid_ff, mid_in, hi_ff, hi_in, j_ff, j_in;
   logic              rd_valid_ff, rd_inr_ff, rd_closed_ff;

   logic [SLOT_W-1:0] ord_a_ff, ord_b_ff;
   key_type           vtx_a_ff, vtx_b_ff;
   logic [EF_W-1:0]   ef_a_ff, ef_b_ff;
   logic [EF_W:0]     mt_ff;

   logic [K_W-1:0]    k;
   logic              room;
   logic [SLOT_W-1:0] slot_ld;
   logic [CNT_W-1:0]  base_cnt;
   logic [SUM_W-1:0]  n15, sum1, sum2, run_step;
   logic [CNT_W-1:0]  setup_i;
   logic [W_W-1:0]    setup_w;
   logic [CNT_W-1:0]  setup_mid, setup_hi;
   logic              p_live, q_live, take_q;
   logic [CNT_W-1:0]  j1;
   logic              setup;

   assign k        = clamp_k(vpf_ff);
   assign base_cnt = closed_ff ? '0 : count_ff;
   assign room     = base_cnt < CNT_W'(MAX_FACES);
   assign slot_ld  = base_cnt[SLOT_W-1:0];
   assign n15      = SUM_W'(count_ff);
   assign run_step = SUM_W'(i_ff) + (SUM_W'(w_ff) << 1);
   assign setup    = cmd.first_run || cmd.next_run || cmd.pass_end;
   assign setup_i  = cmd.next_run ? run_step[CNT_W-1:0] : '0;
   assign setup_w  = cmd.pass_end ? (w_ff << 1) : w_ff;
   assign sum1     = SUM_W'(setup_i) + SUM_W'(setup_w);
   assign sum2     = sum1 + SUM_W'(setup_w);
   assign setup_mid = (sum1 < n15) ? sum1[CNT_W-1:0] : count_ff;
   assign setup_hi  = (sum2 < n15) ? sum2[CNT_W-1:0] : count_ff;
   assign p_live   = p_ff < mid_ff;
   assign q_live   = q_ff < hi_ff;
   assign take_q   = !p_live || (q_live && tuple_after(vtx_a_ff, vtx_b_ff, k));
   assign j1       = j_ff + CNT_W'(1);

   assign status.init_left   = o_ff < count_ff;
   assign status.n_gt1       = count_ff > CNT_W'(1);
   assign status.run_left    = p_live || q_live;
   assign status.more_runs   = run_step < n15;
   assign status.more_passes = (SUM_W'(w_ff) << 1) < n15;
   assign status.scan_left   = j_ff < count_ff;
   assign status.pair_eq     = (j1 < count_ff) && tuple_eq(vtx_a_ff, vtx_b_ff, k);

   always_comb begin
      vpf_in    = csr_write_enable ? csr_write_data : vpf_ff;
      count_in  = count_ff;
      closed_in = closed_ff;
      if (cmd.load) begin
         count_in  = room ? base_cnt + CNT_W'(1) : base_cnt;
         closed_in = req_last_face;
      end
      bank_in = cmd.flip ? ~bank_ff : bank_ff;
      w_in = w_ff;
      i_in = i_ff;
      p_in = p_ff;
      q_in = q_ff;
      o_in = o_ff;
      mid_in = mid_ff;
      hi_in = hi_ff;
      j_in = j_ff;
      if (cmd.sort_start) begin
         bank_in = 1'b0;
         w_in    = W_W'(1);
         o_in    = '0;
      end
      if (cmd.init_step) o_in = o_ff + CNT_W'(1);
      if (setup) begin
         w_in   = setup_w;
         i_in   = setup_i;
         p_in   = setup_i;
         o_in   = setup_i;
         q_in   = setup_mid;
         mid_in = setup_mid;
         hi_in  = setup_hi;
      end
      if (cmd.m_cmp) begin
         o_in = o_ff + CNT_W'(1);
         if (take_q) q_in = q_ff + CNT_W'(1);
         else p_in = p_ff + CNT_W'(1);
      end
      if (cmd.scan_start) j_in = '0;
      if (cmd.s_cmp && !status.pair_eq) j_in = j1;
      if (cmd.s_wrb) j_in = j_ff + CNT_W'(2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vpf_ff      <= K_W'(NV);
         count_ff    <= '0;
         closed_ff   <= 1'b0;
         rd_valid_ff <= 1'b0;
      end else begin
         vpf_ff      <= vpf_in;
         count_ff    <= count_in;
         closed_ff   <= closed_in;
         rd_valid_ff <= cmd.read;
      end
   end

   always_ff @(posedge clock) begin
      bank_ff <= bank_in;
      w_ff    <= w_in;
      i_ff    <= i_in;
      p_ff    <= p_in;
      q_ff    <= q_in;
      o_ff    <= o_in;
      mid_ff  <= mid_in;
      hi_ff   <= hi_in;
      j_ff    <= j_in;
      if (cmd.read) begin
         rd_inr_ff    <= CNT_W'(req_slot_index) < count_ff;
         rd_closed_ff <= closed_ff;
      end
   end

   // face records
   always_ff @(posedge clock) begin
      if (cmd.load && room) begin
         vtx_mem[slot_ld] <= sort_key({req_vert_d, req_vert_c, req_vert_b, req_vert_a}, k);
         ef_mem[slot_ld]  <= {req_owner_element, req_face_number};
      end
      if (cmd.m_vtx || cmd.s_vtx) begin
         vtx_a_ff <= vtx_mem[ord_a_ff];
         vtx_b_ff <= vtx_mem[ord_b_ff];
      end
      if (cmd.read || cmd.s_vtx) ef_a_ff <= ef_mem[cmd.read ? req_slot_index : ord_a_ff];
      if (cmd.s_vtx) ef_b_ff <= ef_mem[ord_b_ff];
   end

   // slot order, two banks
   always_ff @(posedge clock) begin
      if (cmd.init_step) ord_mem[{bank_ff, o_ff[SLOT_W-1:0]}] <= o_ff[SLOT_W-1:0];
      if (cmd.m_cmp)
         ord_mem[{~bank_ff, o_ff[SLOT_W-1:0]}] <= take_q ? ord_b_ff : ord_a_ff;
      if (cmd.m_ord || cmd.s_ord) begin
         ord_a_ff <= ord_mem[{bank_ff, cmd.s_ord ? j_ff[SLOT_W-1:0] : p_ff[SLOT_W-1:0]}];
         ord_b_ff <= ord_mem[{bank_ff, cmd.s_ord ? j1[SLOT_W-1:0] : q_ff[SLOT_W-1:0]}];
      end
   end

   // matches: {found, element, face}
   always_ff @(posedge clock) begin
      if (cmd.s_cmp)
         mt_mem[ord_a_ff] <= status.pair_eq ? {1'b1, ef_b_ff} : '0;
      if (cmd.s_wrb)
         mt_mem[ord_b_ff] <= {1'b1, ef_a_ff};
      if (cmd.read) mt_ff <= mt_mem[req_slot_index];
   end

   logic nb_ok;
   assign nb_ok                = rd_inr_ff && rd_closed_ff && mt_ff[EF_W];
   assign rsp_valid            = rd_valid_ff;
   assign rsp_slot_element     = rd_inr_ff ? ef_a_ff[EF_W-1:FACE_W] : '0;
   assign rsp_slot_face        = rd_inr_ff ? ef_a_ff[FACE_W-1:0] : '0;
   assign rsp_neighbor_element = nb_ok ? {1'b0, mt_ff[EF_W-1:FACE_W]} : '1;
   assign rsp_neighbor_face    = nb_ok ? {1'b0, mt_ff[FACE_W-1:0]} : '1;
endmodule
`default_nettype wire

@@ hw/rtl/mesh_face_match_engine.sv @@
// Face match engine. Loads (req_func 0) and slot reads (req_func 1) are taken
// one per cycle while busy is low; a read answers on the rsp_ ports with
// rsp_valid for exactly one cycle, the cycle after it was taken, and the
// receiver cannot stall it. The load with req_last_face set raises busy for
// the sort and match: the slot order is seeded, then a bottom-up merge sort
// runs ceil(log2 n) passes in which each face takes a check, an order-memory
// read, a vertex-memory read and a compare, then a scan checks each adjacent
// pair of sorted faces the same way and writes back each matched pair. A
// batch of one face skips the merge.
// verts_per_face must be written through csr_ only while the engine is idle;
// the block itself does not enforce it.
`default_nettype none
`include "mesh_face_match_engine_macros.svh"
module mesh_face_match_engine
   import mfm_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_write_enable,
   input  wire logic [K_W-1:0]       csr_write_data,
   input  wire logic                 start,
   output logic                      busy,
   input  wire logic                 req_func,
   input  wire logic [VERT_W-1:0]    req_vert_a,
   input  wire logic [VERT_W-1:0]    req_vert_b,
   input  wire logic [VERT_W-1:0]    req_vert_c,
   input  wire logic [VERT_W-1:0]    req_vert_d,
   input  wire logic [ELT_W-1:0]     req_owner_element,
   input  wire logic [FACE_W-1:0]    req_face_number,
   input  wire logic [SLOT_W-1:0]    req_slot_index,
   input  wire logic                 req_last_face,
   output logic                      rsp_valid,
   output logic [ELT_W-1:0]          rsp_slot_element,
   output logic [FACE_W-1:0]         rsp_slot_face,
   output logic signed [ELT_W:0]     rsp_neighbor_element,
   output logic signed [FACE_W:0]    rsp_neighbor_face
);
   dp_cmd_type    cmd;
   dp_status_type status;

   // sequencer: load/read dispatch, seed, merge passes, pair scan
   mfm_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_func      (req_func),
      .req_last_face (req_last_face),
      .status        (status),
      .busy          (busy),
      .cmd           (cmd)
   );

   // memories, sort counters, key compare
   mfm_datapath u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .csr_write_enable     (csr_write_enable),
      .csr_write_data       (csr_write_data),
      .req_vert_a           (req_vert_a),
      .req_vert_b           (req_vert_b),
      .req_vert_c           (req_vert_c),
      .req_vert_d           (req_vert_d),
      .req_owner_element    (req_owner_element),
      .req_face_number      (req_face_number),
      .req_slot_index       (req_slot_index),
      .req_last_face        (req_last_face),
      .rsp_valid            (rsp_valid),
      .rsp_slot_element     (rsp_slot_element),
      .rsp_slot_face        (rsp_slot_face),
      .rsp_neighbor_element (rsp_neighbor_element),
      .rsp_neighbor_face    (rsp_neighbor_face)
   );

   // a taken read always answers next cycle
   `MFM_ASSERT_NXT(a_read_answers, clock, reset, start && !busy && req_func == FUNC_READ, rsp_valid)
   // no answer word while sorting
   `MFM_ASSERT_IMP(a_no_rsp_busy, clock, reset, rsp_valid, !busy)
   // sorting only follows a last load
   `MFM_ASSERT_IMP(a_busy_cause, clock, reset, $rose(busy),
                   $past(start) && $past(req_func) == FUNC_LOAD && $past(req_last_face))
   // merge and scan steps never overlap
   `MFM_ASSERT_IMP(a_cmd_excl, clock, reset, cmd.m_cmp || cmd.s_cmp,
                   !(cmd.m_cmp && cmd.s_cmp) && !cmd.load)
endmodule
`default_nettype wire
